/* design/otq_pkg.sv */
// Shared types, widths and codes of the one-shot timer queue.
package otq_pkg;

  // Field widths fixed by the interface.
  localparam int ID_W    = 8;
  localparam int DELAY_W = 16;
  localparam int TIME_W  = 32;
  localparam int PEND_W  = 7;

  // Default list capacity.
  localparam int MAX_TASKS_DEF = 8;

  // Input operation codes.
  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  // Result kind codes.
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_FIRE = 1'b1;

  typedef logic [PEND_W-1:0] pend_t;
  typedef logic [TIME_W-1:0] time_t;

  // Operation of the shared adder.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  // One stored timer.
  typedef struct packed {
    logic [ID_W-1:0] id;
    time_t           deadline;
  } entry_t;

endpackage

/* design/otq_alu.sv */
// Shared 32-bit add/subtract unit used for deadlines, the tick and the due test.
module otq_alu (
  input  otq_pkg::alu_op_e op_i,
  input  otq_pkg::time_t   a_i,
  input  otq_pkg::time_t   b_i,
  output otq_pkg::time_t   res_o
);

  // Modulo 2^32 sum or difference.
  always_comb begin
    unique case (op_i)
      otq_pkg::ALU_ADD: res_o = a_i + b_i;
      otq_pkg::ALU_SUB: res_o = a_i - b_i;
      default:          res_o = a_i + b_i;
    endcase
  end

endmodule

/* design/otq_mem.sv */
// Timer list storage: one write port and one registered read port.
module otq_mem #(
  parameter int DEPTH = otq_pkg::MAX_TASKS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  otq_pkg::entry_t                          wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output otq_pkg::entry_t                          rdata_o
);

  otq_pkg::entry_t mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* design/one_shot_timer_queue.sv */
// Top level of the one-shot timer queue: sequencer, counters and output register.
//
// Usage: the input channel takes one beat per operation. A schedule beat stores
// task_id with deadline now + delay_ms if a slot is free and yields one
// acknowledgement beat (accepted = 0 when the list is full). A tick beat advances
// the millisecond counter and yields one report beat per due task, in list order,
// the final one with last = 1; a tick with nothing due yields no beat.
// Every result carries the number of timers still waiting after that operation.
// Timing: the block takes one operation at a time. A schedule moves to the S_ACK
// state, which registers its acknowledgement once the output register is free and
// then frees the input. A tick makes a first pass over the stored timers that
// counts the due timers, and, when any are due, a second pass that reports and
// compacts; both passes are set by the single read port of the list memory and
// the one shared subtractor. A receiver that stalls holds the second pass in
// place until the pending report is taken.
// Reset clears the counter and empties the list; no clearing pass is needed.
module one_shot_timer_queue #(
  parameter int MAX_TASKS = otq_pkg::MAX_TASKS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        operation_i,
  input  logic [otq_pkg::ID_W-1:0]    task_id_i,
  input  logic [otq_pkg::DELAY_W-1:0] delay_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        kind_o,
  output logic                        accepted_o,
  output logic [otq_pkg::ID_W-1:0]    fired_id_o,
  output logic                        last_o,
  output logic [otq_pkg::PEND_W-1:0]  pending_o
);

  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TASKS);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACK  = 3'd1;
  localparam logic [2:0] S_CNT  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_EV   = 3'd4;

  logic [2:0]       state_q, state_d;
  otq_pkg::time_t   now_q, now_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] iss_q, iss_d;
  logic             rd_vld_q, rd_vld_d;
  logic [CNT_W-1:0] nfire_q, nfire_d;
  logic [CNT_W-1:0] fired_k_q, fired_k_d;
  logic [CNT_W-1:0] keep_q, keep_d;
  logic             acc_q, acc_d;
  otq_pkg::pend_t   pend_q, pend_d;

  // Output register.
  logic                     out_valid_q, out_valid_d;
  logic                     kind_q, kind_d;
  logic                     accepted_q, accepted_d;
  logic [otq_pkg::ID_W-1:0] fired_id_q, fired_id_d;
  logic                     last_q, last_d;
  otq_pkg::pend_t           pending_q, pending_d;

  // Memory and shared unit connections.
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  otq_pkg::entry_t  mem_wdata, mem_rdata;
  otq_pkg::alu_op_e alu_op;
  otq_pkg::time_t   alu_a, alu_b, alu_res;

  logic out_free;
  logic due;

  otq_mem #(
    .DEPTH (MAX_TASKS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  otq_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign due        = !alu_res[otq_pkg::TIME_W-1];
  assign in_ready_o = (state_q == S_IDLE);

  // Operand selection for the shared unit.
  always_comb begin
    alu_op = otq_pkg::ALU_SUB;
    alu_a  = now_q;
    alu_b  = mem_rdata.deadline;
    if (state_q == S_IDLE) begin
      alu_op = otq_pkg::ALU_ADD;
      if (operation_i == otq_pkg::OP_TICK) begin
        alu_b = otq_pkg::time_t'(1);
      end else begin
        alu_b = otq_pkg::time_t'(delay_ms_i);
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    count_d     = count_q;
    iss_d       = iss_q;
    rd_vld_d    = 1'b0;
    nfire_d     = nfire_q;
    fired_k_d   = fired_k_q;
    keep_d      = keep_q;
    acc_d       = acc_q;
    pend_d      = pend_q;
    mem_we      = 1'b0;
    mem_waddr   = count_q[IDX_W-1:0];
    mem_wdata   = '{id: task_id_i, deadline: alu_res};
    mem_re      = 1'b0;
    mem_raddr   = iss_q[IDX_W-1:0];
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    accepted_d  = accepted_q;
    fired_id_d  = fired_id_q;
    last_d      = last_q;
    pending_d   = pending_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (operation_i == otq_pkg::OP_SCHEDULE) begin
            acc_d = (count_q < MAX_CNT);
            if (count_q < MAX_CNT) begin
              mem_we  = 1'b1;
              count_d = count_q + ONE_CNT;
            end
            state_d = S_ACK;
          end else begin
            now_d   = alu_res;
            iss_d   = '0;
            nfire_d = '0;
            if (count_q != '0) begin
              state_d = S_CNT;
            end
          end
        end
      end

      S_ACK: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = otq_pkg::KIND_ACK;
          accepted_d  = acc_q;
          fired_id_d  = '0;
          last_d      = 1'b1;
          pending_d   = otq_pkg::pend_t'(count_q);
          state_d     = S_IDLE;
        end
      end

      // First pass: count the due timers, one read issued per cycle.
      S_CNT: begin
        if (iss_q != count_q) begin
          mem_re   = 1'b1;
          iss_d    = iss_q + ONE_CNT;
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q && due) begin
          nfire_d = nfire_q + ONE_CNT;
        end
        if (iss_q == count_q && !rd_vld_q) begin
          if (nfire_q == '0) begin
            state_d = S_IDLE;
          end else begin
            pend_d    = otq_pkg::pend_t'(count_q - nfire_q);
            iss_d     = '0;
            keep_d    = '0;
            fired_k_d = '0;
            state_d   = S_RD;
          end
        end
      end

      // Second pass: read the next entry, or close the pass.
      S_RD: begin
        if (iss_q == count_q) begin
          count_d = keep_q;
          state_d = S_IDLE;
        end else begin
          mem_re  = 1'b1;
          state_d = S_EV;
        end
      end

      // Second pass: report a due entry or move a survivor down.
      S_EV: begin
        if (due) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            kind_d      = otq_pkg::KIND_FIRE;
            accepted_d  = 1'b0;
            fired_id_d  = mem_rdata.id;
            last_d      = (fired_k_q + ONE_CNT == nfire_q);
            pending_d   = pend_q;
            fired_k_d   = fired_k_q + ONE_CNT;
            iss_d       = iss_q + ONE_CNT;
            state_d     = S_RD;
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = keep_q[IDX_W-1:0];
          mem_wdata = mem_rdata;
          keep_d    = keep_q + ONE_CNT;
          iss_d     = iss_q + ONE_CNT;
          state_d   = S_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= '0;
      count_q     <= '0;
      iss_q       <= '0;
      rd_vld_q    <= 1'b0;
      nfire_q     <= '0;
      fired_k_q   <= '0;
      keep_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      count_q     <= count_d;
      iss_q       <= iss_d;
      rd_vld_q    <= rd_vld_d;
      nfire_q     <= nfire_d;
      fired_k_q   <= fired_k_d;
      keep_q      <= keep_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    pend_q     <= pend_d;
    kind_q     <= kind_d;
    accepted_q <= accepted_d;
    fired_id_q <= fired_id_d;
    last_q     <= last_d;
    pending_q  <= pending_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign accepted_o  = accepted_q;
  assign fired_id_o  = fired_id_q;
  assign last_o      = last_q;
  assign pending_o   = pending_q;

  // The list never holds more timers than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= MAX_CNT)
    else $error("timer count exceeds capacity");

  // Compaction never writes ahead of the entry being examined.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EV) |-> (keep_q <= iss_q) && (iss_q < count_q))
    else $error("compaction overtook the read pointer");

  // No more reports go out on a tick than the first pass counted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EV) && due) |-> (fired_k_q < nfire_q))
    else $error("more reports than due timers");

  // A tick over an empty list returns straight to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (operation_i == otq_pkg::OP_TICK) && (count_q == '0))
    |=> in_ready_o)
    else $error("tick on empty list did not return to idle");

endmodule
